// ===== rtl/core/ffhl_pkg.sv =====
package ffhl_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned SizeW = 24;
  localparam int unsigned NeedW = SizeW + 2;
  localparam logic [SizeW-1:0] PoolSizeRst = 24'h100000;
  localparam logic [AddrW-1:0] WordMask = 32'hfffffffc;
  localparam logic [1:0] LowBits = 2'h3;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } ffhl_cmd_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_IGNORED = 2'd2
  } ffhl_status_e;

  typedef enum logic {
    REG_POOL_BASE = 1'b0,
    REG_POOL_SIZE = 1'b1
  } ffhl_reg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_A,
    S_FIX_A,
    S_POP,
    S_INS,
    S_WALK_F,
    S_LINK,
    S_LINK2,
    S_CRD,
    S_CS,
    S_CN,
    S_CREL,
    S_RES
  } ffhl_state_e;

  typedef struct packed {
    logic             command;
    logic [SizeW-1:0] request_size;
    logic [AddrW-1:0] block_address;
    logic [SizeW-1:0] block_length;
  } ffhl_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [AddrW-1:0] address;
    logic [SizeW-1:0] header_length;
  } ffhl_res_t;

  typedef struct packed {
    logic start;
    logic size;
    logic link;
  } ffhl_wen_t;

endpackage

// ===== rtl/core/first_fit_hole_list_allocator.sv =====
// First-fit hole list allocator with coalescing.
// Requests come in on in_valid_i/in_stall_o with an ffhl_req_t payload;
// every request gives exactly one result on out_valid_o/out_stall_i.
// Allocate walks the address-ordered hole list one hole per cycle and cuts
// from the first hole that fits, unlinking a used-up hole. Free walks the
// list the same way to find its place and then merges with the neighbors.
// A size-0 allocate or a rejected free answers without walking the list.
// The walk through the hole table (one read and one write port) sets the rate.
// One request is in work at a time; a new one is taken while the previous
// result still waits in the output register, but its own result then waits
// until that register drains, so a stalled receiver holds up the block.
// pool_base and pool_size are written over the APB port; the user must do so
// only while idle, which the block itself does not enforce. Each write rebuilds
// the list as one hole spanning the pool (an empty list if pool_size is 0).
// After reset and after each configuration write the block writes the first
// table slot and stalls requests while it does so.
module first_fit_hole_list_allocator #(
  parameter int unsigned HOLE_SLOTS   = 128,
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffhl_pkg::ffhl_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffhl_pkg::ffhl_res_t out_res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import ffhl_pkg::*;

  localparam int unsigned SW = $clog2(HOLE_SLOTS + 1);
  localparam int unsigned IW = $clog2(HOLE_SLOTS);
  localparam logic [SW-1:0] Nil = SW'(HOLE_SLOTS);
  localparam logic [AddrW-1:0] HdrB = AddrW'(HEADER_BYTES);

  ffhl_state_e state_q, state_d;
  logic [SW-1:0] head_q, head_d, sp_q, sp_d, fresh_q, fresh_d;
  logic [AddrW-1:0] base_q, base_d;
  logic [SizeW-1:0] psize_q, psize_d;
  logic init_q, init_d;
  logic out_valid_q, out_valid_d;
  ffhl_res_t out_q, out_d;

  ffhl_req_t req_q, req_d;
  logic [NeedW-1:0] need_q, need_d;
  logic [SW-1:0] hp_q, hp_d, prev_q, prev_d, steps_q, steps_d;
  logic [SW-1:0] ns_q, ns_d, s_q, s_d, nx_q, nx_d, nxlink_q, nxlink_d;
  logic [AddrW-1:0] cs_start_q, cs_start_d;
  logic [SizeW-1:0] cs_size_q, cs_size_d;
  logic [SW-1:0] cs_link_q, cs_link_d;
  logic phase_q, phase_d;
  ffhl_res_t res_q, res_d;

  logic rd_en;
  logic [IW-1:0] rd_addr, wr_addr;
  ffhl_wen_t we;
  logic [AddrW-1:0] wr_start, rd_start;
  logic [SizeW-1:0] wr_size, rd_size;
  logic [SW-1:0] wr_link, rd_link;

  ffhl_mem #(.HOLE_SLOTS(HOLE_SLOTS)) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .we_i      (we),
    .wr_addr_i (wr_addr),
    .wr_start_i(wr_start),
    .wr_size_i (wr_size),
    .wr_link_i (wr_link),
    .rd_start_o(rd_start),
    .rd_size_o (rd_size),
    .rd_link_o (rd_link)
  );

  logic cfg_we, in_acc, out_acc;
  logic [AddrW-1:0] fbase;
  logic [AddrW:0] pool_end;
  logic [SizeW:0] rem, sat_sum;
  logic [SW-1:0] nsteps;
  logic fits, touch, bad_free;

  assign pready   = 1'b1;
  assign cfg_we   = psel && penable && pwrite;
  assign prdata   = (paddr[2] == REG_POOL_SIZE) ? {{(32-SizeW){1'b0}}, psize_q} : base_q;
  assign in_stall_o = !(state_q == S_IDLE && !init_q);
  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_q && !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_res_o = out_q;

  assign fbase    = req_q.block_address - HdrB;
  assign pool_end = {1'b0, base_q} + {{(AddrW-SizeW+1){1'b0}}, psize_q};
  assign bad_free = (in_req_i.block_address < HdrB) ||
                    ((in_req_i.block_address[1:0] & LowBits) != 2'b00) ||
                    ({1'b0, in_req_i.block_address} >= pool_end) ||
                    (in_req_i.block_address < base_q) ||
                    (in_req_i.block_length == '0) ||
                    (sp_q >= Nil && fresh_q >= Nil);
  assign fits     = {2'b00, rd_size} >= need_q;
  assign rem      = {1'b0, rd_size} - need_q[SizeW:0];
  assign nsteps   = steps_q + SW'(1);
  assign touch    = (cs_start_q + {{(AddrW-SizeW){1'b0}}, cs_size_q}) == rd_start;
  assign sat_sum  = {1'b0, cs_size_q} + {1'b0, rd_size};

  always_comb begin
    state_d = state_q;
    head_d = head_q; sp_d = sp_q; fresh_d = fresh_q;
    base_d = base_q; psize_d = psize_q; init_d = init_q;
    out_valid_d = out_valid_q; out_d = out_q;
    req_d = req_q; need_d = need_q; hp_d = hp_q; prev_d = prev_q; steps_d = steps_q;
    ns_d = ns_q; s_d = s_q; nx_d = nx_q; nxlink_d = nxlink_q;
    cs_start_d = cs_start_q; cs_size_d = cs_size_q; cs_link_d = cs_link_q;
    phase_d = phase_q; res_d = res_q;
    rd_en = 1'b0; rd_addr = '0;
    we = '0; wr_addr = '0; wr_start = '0; wr_size = '0; wr_link = Nil;

    if (out_acc) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (init_q) begin
          we = '{start: 1'b1, size: 1'b1, link: 1'b1};
          wr_start = base_q;
          wr_size = psize_q;
          head_d = (psize_q != '0) ? SW'(0) : Nil;
          fresh_d = (psize_q != '0) ? SW'(1) : SW'(0);
          sp_d = Nil;
          init_d = 1'b0;
        end else if (in_acc) begin
          req_d = in_req_i;
          res_d = '{status: ST_DONE, address: '0, header_length: '0};
          prev_d = Nil;
          steps_d = '0;
          if (in_req_i.command == CMD_ALLOC) begin
            need_d = (({2'b00, in_req_i.request_size} + NeedW'(3)) & WordMask[NeedW-1:0])
                     + NeedW'(HEADER_BYTES);
            hp_d = head_q;
            if (in_req_i.request_size == '0 || head_q >= Nil) begin
              res_d.status = ST_NO_MEM;
              state_d = S_RES;
            end else begin
              rd_en = 1'b1;
              rd_addr = head_q[IW-1:0];
              state_d = S_WALK_A;
            end
          end else if (bad_free) begin
            res_d.status = ST_IGNORED;
            state_d = S_RES;
          end else if (sp_q < Nil) begin
            rd_en = 1'b1;
            rd_addr = sp_q[IW-1:0];
            state_d = S_POP;
          end else begin
            ns_d = fresh_q;
            fresh_d = fresh_q + SW'(1);
            state_d = S_INS;
          end
        end
      end
      S_WALK_A: begin
        if (fits) begin
          we.start = 1'b1;
          we.size = 1'b1;
          wr_addr = hp_q[IW-1:0];
          wr_start = rd_start + {{(AddrW-NeedW){1'b0}}, need_q};
          wr_size = rem[SizeW-1:0];
          res_d.address = rd_start + HdrB;
          res_d.header_length = need_q[SizeW-1:0];
          state_d = S_RES;
          if (rem == '0) begin
            we.link = 1'b1;
            wr_link = sp_q;
            sp_d = hp_q;
            if (hp_q == head_q) begin
              head_d = rd_link;
            end else if (prev_q < Nil) begin
              nxlink_d = rd_link;
              state_d = S_FIX_A;
            end
          end
        end else if (rd_link < Nil && nsteps < Nil) begin
          rd_en = 1'b1;
          rd_addr = rd_link[IW-1:0];
          prev_d = hp_q;
          hp_d = rd_link;
          steps_d = nsteps;
        end else begin
          res_d.status = ST_NO_MEM;
          state_d = S_RES;
        end
      end
      S_FIX_A: begin
        we.link = 1'b1;
        wr_addr = prev_q[IW-1:0];
        wr_link = nxlink_q;
        state_d = S_RES;
      end
      S_POP: begin
        ns_d = sp_q;
        sp_d = rd_link;
        state_d = S_INS;
      end
      S_INS: begin
        we.start = 1'b1;
        we.size = 1'b1;
        wr_addr = ns_q[IW-1:0];
        wr_start = fbase;
        wr_size = req_q.block_length;
        hp_d = head_q;
        if (head_q < Nil) begin
          rd_en = 1'b1;
          rd_addr = head_q[IW-1:0];
          state_d = S_WALK_F;
        end else begin
          state_d = S_LINK;
        end
      end
      S_WALK_F: begin
        if (fbase > rd_start) begin
          prev_d = hp_q;
          hp_d = rd_link;
          steps_d = nsteps;
          if (rd_link < Nil && nsteps < Nil) begin
            rd_en = 1'b1;
            rd_addr = rd_link[IW-1:0];
          end else begin
            state_d = S_LINK;
          end
        end else begin
          state_d = S_LINK;
        end
      end
      S_LINK: begin
        we.link = 1'b1;
        wr_addr = ns_q[IW-1:0];
        wr_link = hp_q;
        if (prev_q >= Nil) begin
          head_d = ns_q;
          s_d = ns_q;
          state_d = S_CRD;
        end else begin
          state_d = S_LINK2;
        end
      end
      S_LINK2: begin
        we.link = 1'b1;
        wr_addr = prev_q[IW-1:0];
        wr_link = ns_q;
        s_d = prev_q;
        state_d = S_CRD;
      end
      S_CRD: begin
        rd_en = 1'b1;
        rd_addr = s_q[IW-1:0];
        phase_d = 1'b0;
        state_d = S_CS;
      end
      S_CS: begin
        cs_start_d = rd_start;
        cs_size_d = rd_size;
        cs_link_d = rd_link;
        if (rd_link < Nil) begin
          rd_en = 1'b1;
          rd_addr = rd_link[IW-1:0];
          nx_d = rd_link;
          state_d = S_CN;
        end else begin
          state_d = S_RES;
        end
      end
      S_CN: begin
        if (touch) begin
          we.size = 1'b1;
          wr_addr = s_q[IW-1:0];
          wr_size = sat_sum[SizeW] ? {SizeW{1'b1}} : sat_sum[SizeW-1:0];
          cs_size_d = wr_size;
          nxlink_d = rd_link;
          if (nx_q == head_q) begin
            head_d = rd_link;
          end else begin
            we.link = 1'b1;
            wr_link = rd_link;
            cs_link_d = rd_link;
          end
          state_d = S_CREL;
        end else if (!phase_q) begin
          phase_d = 1'b1;
          s_d = nx_q;
          cs_start_d = rd_start;
          cs_size_d = rd_size;
          cs_link_d = rd_link;
          if (rd_link < Nil) begin
            rd_en = 1'b1;
            rd_addr = rd_link[IW-1:0];
            nx_d = rd_link;
          end else begin
            state_d = S_RES;
          end
        end else begin
          state_d = S_RES;
        end
      end
      S_CREL: begin
        we.link = 1'b1;
        wr_addr = nx_q[IW-1:0];
        wr_link = sp_q;
        sp_d = nx_q;
        state_d = S_RES;
        if (!phase_q) begin
          phase_d = 1'b1;
          if (cs_link_q < Nil) begin
            rd_en = 1'b1;
            rd_addr = cs_link_q[IW-1:0];
            nx_d = cs_link_q;
            state_d = S_CN;
          end
        end
      end
      S_RES: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = res_q;
          out_valid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we) begin
      if (paddr[2] == REG_POOL_SIZE) psize_d = pwdata[SizeW-1:0];
      else base_d = pwdata;
      init_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q <= '0;
      sp_q <= Nil;
      fresh_q <= SW'(1);
      base_q <= '0;
      psize_q <= PoolSizeRst;
      init_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q <= head_d;
      sp_q <= sp_d;
      fresh_q <= fresh_d;
      base_q <= base_d;
      psize_q <= psize_d;
      init_q <= init_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    req_q <= req_d;
    need_q <= need_d;
    hp_q <= hp_d;
    prev_q <= prev_d;
    steps_q <= steps_d;
    ns_q <= ns_d;
    s_q <= s_d;
    nx_q <= nx_d;
    nxlink_q <= nxlink_d;
    cs_start_q <= cs_start_d;
    cs_size_q <= cs_size_d;
    cs_link_q <= cs_link_d;
    phase_q <= phase_d;
    res_q <= res_d;
  end

  a_res_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RES && !out_valid_q) |=> out_valid_q)
    else $error("result not loaded");

  a_fresh_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= Nil)
    else $error("fresh slot count out of range");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q != S_IDLE)
    else $error("accepted request not started");

endmodule

// ===== rtl/core/ffhl_mem.sv =====
module ffhl_mem #(
  parameter int unsigned HOLE_SLOTS = 128
) (
  input  logic                                  clk_i,
  input  logic                                  rd_en_i,
  input  logic [$clog2(HOLE_SLOTS)-1:0]         rd_addr_i,
  input  ffhl_pkg::ffhl_wen_t                   we_i,
  input  logic [$clog2(HOLE_SLOTS)-1:0]         wr_addr_i,
  input  logic [ffhl_pkg::AddrW-1:0]            wr_start_i,
  input  logic [ffhl_pkg::SizeW-1:0]            wr_size_i,
  input  logic [$clog2(HOLE_SLOTS+1)-1:0]       wr_link_i,
  output logic [ffhl_pkg::AddrW-1:0]            rd_start_o,
  output logic [ffhl_pkg::SizeW-1:0]            rd_size_o,
  output logic [$clog2(HOLE_SLOTS+1)-1:0]       rd_link_o
);
  import ffhl_pkg::*;

  localparam int unsigned SW = $clog2(HOLE_SLOTS + 1);

  logic [AddrW-1:0] start_mem [HOLE_SLOTS];
  logic [SizeW-1:0] size_mem  [HOLE_SLOTS];
  logic [SW-1:0]    link_mem  [HOLE_SLOTS];

  logic hit;
  assign hit = (wr_addr_i == rd_addr_i);

  always_ff @(posedge clk_i) begin
    if (we_i.start) start_mem[wr_addr_i] <= wr_start_i;
    if (we_i.size)  size_mem[wr_addr_i]  <= wr_size_i;
    if (we_i.link)  link_mem[wr_addr_i]  <= wr_link_i;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_start_o <= (we_i.start && hit) ? wr_start_i : start_mem[rd_addr_i];
      rd_size_o  <= (we_i.size && hit)  ? wr_size_i  : size_mem[rd_addr_i];
      rd_link_o  <= (we_i.link && hit)  ? wr_link_i  : link_mem[rd_addr_i];
    end
  end

endmodule
